// ===== sv/ppds_pkg.sv =====
// Shared types and constants for the PWM period and duty setup block.
// Used by ppds_div and pwm_period_duty_setup; depends on nothing.
package ppds_pkg;

    // Field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned ADDR_W   = 4;

    // Command opcodes
    localparam logic [OPCODE_W-1:0] OP_OFF   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FREQ  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DUTY  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_BOTH  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TICKS = 3'd4;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TICK_RATE = 2'd0;
    localparam logic [1:0] REG_MIN_FREQ  = 2'd1;
    localparam logic [1:0] REG_MAX_FREQ  = 2'd2;

    // Reset values
    localparam logic [WORD_W-1:0]  TICK_RATE_RST = 32'd80000000;
    localparam logic [WORD_W-1:0]  MIN_FREQ_RST  = 32'd1;
    localparam logic [WORD_W-1:0]  MAX_FREQ_RST  = 32'd100000;
    localparam logic [TIMER_W-1:0] RELOAD_MAX    = 16'hFFFF;
    localparam logic [DUTY_W-1:0]  DUTY_MAX      = 8'd100;

    // Request to the serial divider
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } ppds_div_req_t;

endpackage

// ===== sv/ppds_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ppds_pkg for the request struct and word width.
module ppds_div
    import ppds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ppds_div_req_t       req,
    output logic                done,
    output logic [WORD_W-1:0]   quotient
);

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              ge;

    // One shift-subtract step; a zero divisor yields an all-ones quotient
    always_comb
    begin
        trial = {rem_reg, quo_reg[WORD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/pwm_period_duty_setup.sv =====
// PWM period and duty setup: command sequencer, timer state and APB registers.
// Depends on ppds_pkg and ppds_div (shared serial divider).
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | opcode, frequency_hz, duty_pct,
//           |                      | high_ticks, low_ticks
//  out      | out_valid / out_stall| reload_value, compare_value, running,
//           |                      | remembered_duty, counter_cleared
//  apb      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// One command at a time, stalled from its accept until its result word commits:
// off and unused opcodes go straight to commit, set frequency and set ticks run
// one division, set duty one duty apply, set both or a reapplied duty both.
// The shared divider makes one quotient bit per cycle; a duty apply divides by 100.
// Reset returns reload 65535, compare 0, stopped, duty 0 and default registers.
// A waiting result word holds the next command's state update, not its accept.
module pwm_period_duty_setup
    import ppds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // command input
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [WORD_W-1:0]   frequency_hz,
    input  logic [DUTY_W-1:0]   duty_pct,
    input  logic [WORD_W-1:0]   high_ticks,
    input  logic [WORD_W-1:0]   low_ticks,
    // result output
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TIMER_W-1:0]  reload_value,
    output logic [TIMER_W-1:0]  compare_value,
    output logic                running,
    output logic [DUTY_W-1:0]   remembered_duty,
    output logic                counter_cleared,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_WQ   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WD   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int unsigned TOP_W  = TIMER_W + 1;
    localparam int unsigned DCAP_W = 7;
    localparam int unsigned PROD_W = TOP_W + DCAP_W;

    // configuration registers
    logic [WORD_W-1:0] tick_rate_reg, min_freq_reg, max_freq_reg;
    logic              cfg_wr;

    // control
    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // latched command
    logic [OPCODE_W-1:0] op_reg;
    logic [WORD_W-1:0]   freq_reg, on_reg, offt_reg;
    logic [DUTY_W-1:0]   duty_reg;

    // work values
    logic [TIMER_W-1:0] work_reload_reg, work_reload_next;
    logic [TIMER_W-1:0] work_cmp_reg, work_cmp_next;
    logic [DUTY_W-1:0]  work_kept_reg, work_kept_next;
    logic               off_cmd_reg, off_cmd_next;
    logic               apply_reg, apply_next;

    // timer state, shown on the output
    logic [TIMER_W-1:0] reload_reg, reload_next;
    logic [TIMER_W-1:0] compare_reg, compare_next;
    logic               started_reg, started_next;
    logic [DUTY_W-1:0]  kept_reg, kept_next;
    logic               cleared_reg, cleared_next;

    // datapath helpers
    ppds_div_req_t      div_req;
    logic               div_done;
    logic [WORD_W-1:0]  div_q;
    logic               is_off;
    logic [WORD_W-1:0]  freq_clamped;
    logic [TIMER_W-1:0] tick_a, tick_b;
    logic [TOP_W-1:0]   tick_sum;
    logic [TIMER_W-1:0] tick_arr;
    logic [TIMER_W-1:0] tick_cmp;
    logic [WORD_W-1:0]  tick_pct;
    logic [TIMER_W-1:0] reload_from_q;
    logic [DUTY_W-1:0]  duty_src;
    logic [DCAP_W-1:0]  duty_cap;
    logic [TOP_W-1:0]   top;
    logic [PROD_W-1:0]  product;
    logic               commit;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= TICK_RATE_RST;
            min_freq_reg  <= MIN_FREQ_RST;
            max_freq_reg  <= MAX_FREQ_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TICK_RATE: tick_rate_reg <= pwdata;
                REG_MIN_FREQ:  min_freq_reg  <= pwdata;
                REG_MAX_FREQ:  max_freq_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TICK_RATE: prdata = tick_rate_reg;
            REG_MIN_FREQ:  prdata = min_freq_reg;
            REG_MAX_FREQ:  prdata = max_freq_reg;
            default:       prdata = '0;
        endcase
    end

    // Command decode: which commands fall back to the off action
    always_comb
    begin
        case (op_reg)
            OP_OFF:   is_off = 1'b1;
            OP_DUTY:  is_off = (duty_reg == '0);
            OP_BOTH:  is_off = (duty_reg == '0) || (freq_reg == '0);
            OP_TICKS: is_off = (on_reg == '0);
            default:  is_off = 1'b0;
        endcase
    end

    // Frequency clamp, lower bound tested first
    always_comb
    begin
        if (freq_reg < min_freq_reg)
            freq_clamped = min_freq_reg;
        else if (freq_reg > max_freq_reg)
            freq_clamped = max_freq_reg;
        else
            freq_clamped = freq_reg;
    end

    // Tick mode: clamp on/off times, reload, compare and percent dividend
    always_comb
    begin
        tick_a = (on_reg > {16'd0, RELOAD_MAX}) ? RELOAD_MAX : on_reg[TIMER_W-1:0];
        if (offt_reg == '0)
            tick_b = 16'd1;
        else if (offt_reg > {16'd0, RELOAD_MAX})
            tick_b = RELOAD_MAX;
        else
            tick_b = offt_reg[TIMER_W-1:0];
        tick_sum = {1'b0, tick_a} + {1'b0, tick_b} - 17'd1;
        tick_arr = tick_sum[TIMER_W] ? RELOAD_MAX : tick_sum[TIMER_W-1:0];
        tick_cmp = (tick_a - 16'd1 > tick_arr) ? tick_arr : tick_a - 16'd1;
        // 100 * a as shifts: 64a + 32a + 4a
        tick_pct = ({16'd0, tick_a} << 6) + ({16'd0, tick_a} << 5) + ({16'd0, tick_a} << 2);
    end

    // Reload from quotient: zero or one quotient gives 1, large values saturate
    always_comb
    begin
        if (div_q < 32'd2)
            reload_from_q = 16'd1;
        else if (div_q > 32'h0001_0000)
            reload_from_q = RELOAD_MAX;
        else
            reload_from_q = div_q[TIMER_W-1:0] - 16'd1;
    end

    // Duty apply product: (reload + 1) * min(duty, 100)
    always_comb
    begin
        duty_src = (op_reg == OP_FREQ) ? kept_reg : duty_reg;
        duty_cap = (duty_src > DUTY_MAX) ? DUTY_MAX[DCAP_W-1:0] : duty_src[DCAP_W-1:0];
        top      = {1'b0, work_reload_reg} + 17'd1;
        product  = top * duty_cap;
    end

    assign commit = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        work_reload_next = work_reload_reg;
        work_cmp_next    = work_cmp_reg;
        work_kept_next   = work_kept_reg;
        off_cmd_next     = off_cmd_reg;
        apply_next       = apply_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                off_cmd_next     = is_off;
                apply_next       = 1'b0;
                work_reload_next = reload_reg;
                if (is_off)
                    state_next = S_FIN;
                else
                begin
                    case (op_reg) inside
                        OP_FREQ, OP_BOTH:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = tick_rate_reg;
                            div_req.divisor  = freq_clamped;
                            state_next       = S_WQ;
                        end
                        OP_DUTY:
                            state_next = S_MUL;
                        OP_TICKS:
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = tick_pct;
                            div_req.divisor  = {15'd0, tick_sum + 17'd1};
                            work_reload_next = tick_arr;
                            work_cmp_next    = tick_cmp;
                            state_next       = S_WQ;
                        end
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_WQ:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_TICKS)
                    begin
                        work_kept_next = div_q[DUTY_W-1:0];
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        work_reload_next = reload_from_q;
                        if (op_reg == OP_BOTH || (started_reg && kept_reg != '0))
                            state_next = S_MUL;
                        else
                            state_next = S_FIN;
                    end
                end
            end
            S_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {{(WORD_W-PROD_W){1'b0}}, product};
                div_req.divisor  = {24'd0, DUTY_MAX};
                apply_next       = 1'b1;
                state_next       = S_WD;
            end
            S_WD:
            begin
                if (div_done)
                begin
                    if (div_q > {16'd0, work_reload_reg})
                        work_cmp_next = work_reload_reg;
                    else
                        work_cmp_next = div_q[TIMER_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Timer state update at the end of a command
    always_comb
    begin
        reload_next  = reload_reg;
        compare_next = compare_reg;
        started_next = started_reg;
        kept_next    = kept_reg;
        cleared_next = cleared_reg;
        if (commit)
        begin
            cleared_next = 1'b0;
            if (off_cmd_reg)
            begin
                if (started_reg)
                begin
                    compare_next = '0;
                    started_next = 1'b0;
                end
                kept_next = '0;
            end
            else
            begin
                case (op_reg)
                    OP_FREQ:
                    begin
                        reload_next  = work_reload_reg;
                        if (apply_reg)
                            compare_next = work_cmp_reg;
                        cleared_next = 1'b1;
                    end
                    OP_DUTY:
                    begin
                        compare_next = work_cmp_reg;
                        started_next = 1'b1;
                        kept_next    = duty_reg;
                    end
                    OP_BOTH:
                    begin
                        reload_next  = work_reload_reg;
                        compare_next = work_cmp_reg;
                        started_next = 1'b1;
                        kept_next    = duty_reg;
                        cleared_next = 1'b1;
                    end
                    OP_TICKS:
                    begin
                        reload_next  = work_reload_reg;
                        compare_next = work_cmp_reg;
                        started_next = 1'b1;
                        kept_next    = work_kept_reg;
                        cleared_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Output word handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            reload_reg    <= RELOAD_MAX;
            compare_reg   <= '0;
            started_reg   <= 1'b0;
            kept_reg      <= '0;
            cleared_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            reload_reg    <= reload_next;
            compare_reg   <= compare_next;
            started_reg   <= started_next;
            kept_reg      <= kept_next;
            cleared_reg   <= cleared_next;
        end
    end

    // Command latch and work registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= opcode;
            freq_reg <= frequency_hz;
            duty_reg <= duty_pct;
            on_reg   <= high_ticks;
            offt_reg <= low_ticks;
        end
        work_reload_reg <= work_reload_next;
        work_cmp_reg    <= work_cmp_next;
        work_kept_reg   <= work_kept_next;
        off_cmd_reg     <= off_cmd_next;
        apply_reg       <= apply_next;
    end

    ppds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign reload_value    = reload_reg;
    assign compare_value   = compare_reg;
    assign running         = started_reg;
    assign remembered_duty = kept_reg;
    assign counter_cleared = cleared_reg;

    // A new output word appears only from the commit step
    a_word_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("output word raised outside commit");

    // Timer state changes only when a command commits
    a_state_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(reload_reg) || !$stable(compare_reg) |-> $past(commit))
        else $error("timer state changed outside commit");

    // Reload never drops to zero
    a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        reload_reg != '0)
        else $error("reload zero");

    // Divider results arrive only while the sequencer waits for them
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_WQ || state_reg == S_WD)
        else $error("divider finished outside a wait state");

endmodule
